### sv/timed_dual_rail_switch_core_macros.svh
// ----------------------------------------------------------------------------
// timed dual rail switch core assertion macros
// Property shorthands used by the switch core; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef TIMED_DUAL_RAIL_SWITCH_CORE_MACROS_SVH
`define TIMED_DUAL_RAIL_SWITCH_CORE_MACROS_SVH

`ifndef SYNTH
// same-cycle implication, sampled on clk, off during rst
`define TDRS_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("tdrs assertion failed");
// next-cycle implication, sampled on clk, off during rst
`define TDRS_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("tdrs assertion failed");
`else
`define TDRS_ASSERT_NOW(lbl, pre, post)
`define TDRS_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

### sv/tdrs_pkg.sv
// ----------------------------------------------------------------------------
// tdrs_pkg
// Shared widths, action codes, rail state type and saturation helpers.
// ----------------------------------------------------------------------------
package tdrs_pkg;

  // countdown width of each rail timer
  localparam int TIMER_WIDTH = 24;
  // fixed field widths
  localparam int DELAY_WIDTH = 24;
  localparam int OUT_WIDTH   = 24;
  localparam int ACTION_WIDTH = 3;
  localparam int MASK_WIDTH   = 2;

  typedef enum logic [ACTION_WIDTH-1:0] {
    ACT_SET          = 3'd0,
    ACT_TOGGLE       = 3'd1,
    ACT_FOR_DURATION = 3'd2,
    ACT_SCHEDULE     = 3'd3,
    ACT_CANCEL       = 3'd4,
    ACT_TICK         = 3'd5,
    ACT_QUERY        = 3'd6
  } action_t;

  // mask value that selects the high rail for the reported count
  localparam logic [MASK_WIDTH-1:0] MASK_HIGH_ONLY = 2'b10;

  typedef struct packed {
    logic                   on;
    logic                   running;
    logic                   level;
    logic [TIMER_WIDTH-1:0] count;
  } rail_state_t;

  // clamp a delay field to the timer range
  function automatic logic [TIMER_WIDTH-1:0] sat_delay(input logic [DELAY_WIDTH-1:0] d);
    logic [TIMER_WIDTH-1:0] r;
    if ((d >> TIMER_WIDTH) != '0) begin
      r = '1;
    end else begin
      r = TIMER_WIDTH'(d);
    end
    return r;
  endfunction

  // clamp a timer count to the output field
  function automatic logic [OUT_WIDTH-1:0] sat_out(input logic [TIMER_WIDTH-1:0] c);
    logic [OUT_WIDTH-1:0] r;
    if ((c >> OUT_WIDTH) != '0) begin
      r = '1;
    end else begin
      r = OUT_WIDTH'(c);
    end
    return r;
  endfunction

endpackage

### sv/tdrs_rail_unit.sv
// ----------------------------------------------------------------------------
// tdrs_rail_unit
// One rail enable with its one-shot countdown; updates on each accepted beat.
// ----------------------------------------------------------------------------
module tdrs_rail_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step,
  input  tdrs_pkg::action_t                   action,
  input  logic                                chosen,
  input  logic                                target_on,
  input  logic [tdrs_pkg::TIMER_WIDTH-1:0]    delay,
  output tdrs_pkg::rail_state_t               state_next
);
  import tdrs_pkg::*;

  rail_state_t            state;
  rail_state_t            upd;
  logic [TIMER_WIDTH-1:0] count_dec;

  // decrement that holds at zero
  assign count_dec = (state.count != '0) ? state.count - 1'b1 : state.count;

  // per-action update of this rail
  always_comb begin
    upd = state;
    unique case (action)
      ACT_SET: begin
        if (chosen) begin
          upd.on      = target_on;
          upd.running = 1'b0;
          upd.count   = '0;
        end
      end
      ACT_TOGGLE: begin
        if (chosen) begin
          upd.on      = ~state.on;
          upd.running = 1'b0;
          upd.count   = '0;
        end
      end
      ACT_FOR_DURATION: begin
        if (chosen) begin
          if (delay == '0) begin
            upd.on      = 1'b0;
            upd.running = 1'b0;
            upd.count   = '0;
          end else begin
            upd.on      = 1'b1;
            upd.level   = 1'b0;
            upd.count   = delay;
            upd.running = 1'b1;
          end
        end
      end
      ACT_SCHEDULE: begin
        if (chosen) begin
          if (delay == '0) begin
            upd.on      = target_on;
            upd.running = 1'b0;
            upd.count   = '0;
          end else begin
            upd.level   = target_on;
            upd.count   = delay;
            upd.running = 1'b1;
          end
        end
      end
      ACT_CANCEL: begin
        if (chosen) begin
          upd.running = 1'b0;
          upd.count   = '0;
        end
      end
      ACT_TICK: begin
        if (state.running) begin
          upd.count = count_dec;
          if (count_dec == '0) begin
            upd.on      = state.level;
            upd.running = 1'b0;
          end
        end
      end
      default: begin
        upd = state;
      end
    endcase
  end

  assign state_next = step ? upd : state;

  // rail state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else begin
      state <= state_next;
    end
  end

endmodule

### sv/timed_dual_rail_switch_core.sv
// ----------------------------------------------------------------------------
// timed_dual_rail_switch_core
// Two rail enables with one-shot countdown timers, driven by command beats.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one command beat: action,
//   channel_mask, target_on and delay_ticks. Every accepted beat updates the
//   rail state in the cycle it is accepted and yields exactly one result beat
//   on the output channel (out_valid/out_ready): rail enables, timer flags and
//   the remaining count of the rail picked by channel_mask.
//   The result is valid in the cycle after the command is accepted.
//   Throughput: one beat per cycle while out_ready is held high; the single
//   output register is the only stage, so a new command is taken whenever
//   that register is empty or is being drained in the same cycle.
//   Receiver stall: while out_valid is high and out_ready low the result holds
//   and in_ready drops, so no command is taken and the state does not move.
//   Reset (rst, synchronous): both rails off, both timers idle, counts zero,
//   output register empty.
// ----------------------------------------------------------------------------
`include "timed_dual_rail_switch_core_macros.svh"

module timed_dual_rail_switch_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [tdrs_pkg::ACTION_WIDTH-1:0]    action,
  input  logic [tdrs_pkg::MASK_WIDTH-1:0]      channel_mask,
  input  logic                                 target_on,
  input  logic [tdrs_pkg::DELAY_WIDTH-1:0]     delay_ticks,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 rail_low_on,
  output logic                                 rail_high_on,
  output logic                                 timer_low_active,
  output logic                                 timer_high_active,
  output logic [tdrs_pkg::OUT_WIDTH-1:0]       remaining_ticks
);
  import tdrs_pkg::*;

  logic                   accept;
  action_t                act;
  logic [TIMER_WIDTH-1:0] delay_sat;
  rail_state_t            low_next;
  rail_state_t            high_next;
  rail_state_t            sel_next;
  logic [OUT_WIDTH-1:0]   rem_next;

  // handshake
  assign in_ready = ~out_valid | out_ready;
  assign accept   = in_valid & in_ready;

  assign act       = action_t'(action);
  assign delay_sat = sat_delay(delay_ticks);

  // per-rail state and update
  tdrs_rail_unit u_rail_low (
    .clk        (clk),
    .rst        (rst),
    .step       (accept),
    .action     (act),
    .chosen     (channel_mask[0]),
    .target_on  (target_on),
    .delay      (delay_sat),
    .state_next (low_next)
  );

  tdrs_rail_unit u_rail_high (
    .clk        (clk),
    .rst        (rst),
    .step       (accept),
    .action     (act),
    .chosen     (channel_mask[1]),
    .target_on  (target_on),
    .delay      (delay_sat),
    .state_next (high_next)
  );

  // reported count from the post-update state
  assign sel_next = (channel_mask == MASK_HIGH_ONLY) ? high_next : low_next;
  assign rem_next = sel_next.running ? sat_out(sel_next.count) : '0;

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rail_low_on       <= low_next.on;
      rail_high_on      <= high_next.on;
      timer_low_active  <= low_next.running;
      timer_high_active <= high_next.running;
      remaining_ticks   <= rem_next;
    end
  end

  // checks
  `TDRS_ASSERT_NEXT(a_accept_gives_result, accept, out_valid)
  `TDRS_ASSERT_NOW(a_low_running_nonzero, low_next.running, low_next.count != '0)
  `TDRS_ASSERT_NOW(a_high_running_nonzero, high_next.running, high_next.count != '0)
  `TDRS_ASSERT_NEXT(a_cancel_stops_low, accept && act == ACT_CANCEL && channel_mask[0], !timer_low_active)

endmodule
